// ===== rtl/topic_filter_validator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// topic filter validator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TOPIC_FILTER_VALIDATOR_UNIT_DEFINES_SVH
`define TOPIC_FILTER_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define TFV_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tfv assertion failed");

// next-cycle implication under reset
`define TFV_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tfv assertion failed");

`endif

// ===== rtl/tfv_pkg.sv =====
// ----------------------------------------------------------------------------
// topic filter validator package
// shared types and character constants
// ----------------------------------------------------------------------------
`default_nettype none

package tfv_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned LVL_W   = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
  localparam logic [LEN_W-1:0]   LEN_SAT     = '1;
  localparam logic [LVL_W-1:0]   LVL_SAT     = 2'd2;
  localparam logic [LVL_W-1:0]   LVL_ONE     = 2'd1;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EMPTY         = 3'd1,
    ST_TOO_LONG      = 3'd2,
    ST_PUB_WILDCARD  = 3'd3,
    ST_BAD_PLACEMENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] topic_byte;
    logic              filter_mode;
  } item_t;

  typedef struct packed {
    logic  go;
    item_t item;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/tfv_in_if.sv =====
// ----------------------------------------------------------------------------
// topic byte channel
// valid/ready stream of topic characters
// ----------------------------------------------------------------------------
`default_nettype none

interface tfv_in_if;
  logic                       valid;
  logic                       ready;
  logic [tfv_pkg::BYTE_W-1:0] topic_byte;
  logic                       filter_mode;

  modport source (output valid, output topic_byte, output filter_mode, input ready);
  modport sink (input valid, input topic_byte, input filter_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfv_out_if.sv =====
// ----------------------------------------------------------------------------
// status channel
// valid/ready stream of topic check results
// ----------------------------------------------------------------------------
`default_nettype none

interface tfv_out_if;
  logic             valid;
  logic             ready;
  tfv_pkg::status_t status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// configuration channel
// valid/ready write of the topic length limit
// ----------------------------------------------------------------------------
`default_nettype none

interface tfv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tfv_pkg::LIMIT_W-1:0] max_topic_length;

  modport source (output valid, output max_topic_length, input ready);
  modport sink (input valid, input max_topic_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfv_core.sv =====
// ----------------------------------------------------------------------------
// topic filter validator check core
// per-topic length and wildcard tracking, status decision on terminator
// ----------------------------------------------------------------------------
`default_nettype none

module tfv_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tfv_pkg::step_t                step,
  input  logic [tfv_pkg::LIMIT_W-1:0]   max_len,
  output tfv_pkg::status_t              status
);
  import tfv_pkg::*;

  logic [LEN_W-1:0] topic_len_r, topic_len_nxt;
  logic [LVL_W-1:0] lvl_len_r, lvl_len_nxt;
  logic             lvl_plus_r, lvl_plus_nxt;
  logic             lvl_hash_r, lvl_hash_nxt;
  logic             wc_err_r, wc_err_nxt;
  logic             mode_r, mode_nxt;

  logic [BYTE_W-1:0] b;
  logic              is_nul, is_plus, is_hash, is_slash;
  logic              mode_cur;
  logic              lvl_not_one;
  logic              err_final;

  assign b        = step.item.topic_byte;
  assign is_nul   = (b == CH_NUL);
  assign is_plus  = (b == CH_PLUS);
  assign is_hash  = (b == CH_HASH);
  assign is_slash = (b == CH_SLASH);
  assign mode_cur = (topic_len_r == '0) ? step.item.filter_mode : mode_r;
  assign lvl_not_one = (lvl_len_r != LVL_ONE);

  // a wildcard error seen so far, or closing the last level in filter mode
  assign err_final = wc_err_r ||
                     (mode_r && (lvl_plus_r || lvl_hash_r) && lvl_not_one);

  always_comb begin
    if (topic_len_r == '0) begin
      status = ST_EMPTY;
    end else if (topic_len_r > {1'b0, max_len}) begin
      status = ST_TOO_LONG;
    end else if (err_final) begin
      status = mode_r ? ST_BAD_PLACEMENT : ST_PUB_WILDCARD;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    topic_len_nxt = topic_len_r;
    lvl_len_nxt   = lvl_len_r;
    lvl_plus_nxt  = lvl_plus_r;
    lvl_hash_nxt  = lvl_hash_r;
    wc_err_nxt    = wc_err_r;
    mode_nxt      = mode_r;
    if (step.go) begin
      if (is_nul) begin
        topic_len_nxt = '0;
        lvl_len_nxt   = '0;
        lvl_plus_nxt  = 1'b0;
        lvl_hash_nxt  = 1'b0;
        wc_err_nxt    = 1'b0;
        mode_nxt      = 1'b0;
      end else begin
        mode_nxt = mode_cur;
        if (topic_len_r != LEN_SAT) begin
          topic_len_nxt = topic_len_r + LEN_W'(1);
        end
        if (!mode_cur) begin
          if (is_plus || is_hash) begin
            wc_err_nxt = 1'b1;
          end
        end else if (is_slash) begin
          // a hash can never close an inner level
          if ((lvl_plus_r && lvl_not_one) || lvl_hash_r) begin
            wc_err_nxt = 1'b1;
          end
          lvl_len_nxt  = '0;
          lvl_plus_nxt = 1'b0;
          lvl_hash_nxt = 1'b0;
        end else begin
          if (is_plus) begin
            lvl_plus_nxt = 1'b1;
          end
          if (is_hash) begin
            lvl_hash_nxt = 1'b1;
          end
          if (lvl_len_r != LVL_SAT) begin
            lvl_len_nxt = lvl_len_r + LVL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topic_len_r <= '0;
      lvl_len_r   <= '0;
      lvl_plus_r  <= 1'b0;
      lvl_hash_r  <= 1'b0;
      wc_err_r    <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      topic_len_r <= topic_len_nxt;
      lvl_len_r   <= lvl_len_nxt;
      lvl_plus_r  <= lvl_plus_nxt;
      lvl_hash_r  <= lvl_hash_nxt;
      wc_err_r    <= wc_err_nxt;
      mode_r      <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/topic_filter_validator_unit.sv =====
// ----------------------------------------------------------------------------
// topic filter validator unit
// checks a zero-terminated topic or filter and reports one status per topic
// ----------------------------------------------------------------------------
//  channel   direction  payload                       handshake
//  in_ch     sink       topic_byte, filter_mode       valid / ready
//  out_ch    source     status                        valid / ready
//  cfg_ch    sink       max_topic_length              valid / ready (always ready)
//
//  one byte is taken per cycle while the input is not stalled; the zero byte of a
//  topic passes the input register, then its status is loaded into the result register
//  in_ch.ready drops only while a zero byte waits on a full, stalled result register
//  reset clears all topic state and sets the length limit to 65535
//  an input register and a result register part the two sides
// ----------------------------------------------------------------------------
`default_nettype none

module topic_filter_validator_unit (
  input  logic      clk,
  input  logic      rst_n,
  tfv_in_if.sink    in_ch,
  tfv_out_if.source out_ch,
  tfv_cfg_if.sink   cfg_ch
);
  import tfv_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  item_t              s1_item_r;
  logic               s1_zero;
  logic               s1_go;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r;
  status_t            core_status;
  logic [LIMIT_W-1:0] max_len_r;
  step_t              step;

  assign s1_zero     = (s1_item_r.topic_byte == CH_NUL);
  assign s1_go       = s1_valid_r && (!s1_zero || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign cfg_ch.ready = 1'b1;

  assign s1_valid_nxt  = in_ch.ready ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = (s1_go && s1_zero) ? 1'b1 :
                         (out_ch.ready ? 1'b0 : out_valid_r);

  assign step.go   = s1_go;
  assign step.item = s1_item_r;

  tfv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .max_len (max_len_r),
    .status  (core_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.max_topic_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.topic_byte  <= in_ch.topic_byte;
      s1_item_r.filter_mode <= in_ch.filter_mode;
    end
    if (s1_go && s1_zero) begin
      status_r <= core_status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;

endmodule

`default_nettype wire

// ===== rtl/tfv_checker.sv =====
// ----------------------------------------------------------------------------
// topic filter validator port checker
// port-level properties, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "topic_filter_validator_unit_defines.svh"

module tfv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input tfv_pkg::status_t out_status,
  input logic             cfg_ready
);
  import tfv_pkg::*;

  // result held while stalled
  `TFV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
  // only known status codes leave
  `TFV_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_status <= ST_BAD_PLACEMENT)
  // input stalls only behind a stalled result
  `TFV_ASSERT_NOW(a_in_backpressure, clk, rst_n, !in_ready, out_valid && !out_ready)
  // limit writes are never refused
  `TFV_ASSERT_NOW(a_cfg_ready, clk, rst_n, in_valid || !in_valid, cfg_ready)

endmodule

bind topic_filter_validator_unit tfv_checker u_tfv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .cfg_ready  (cfg_ch.ready)
);

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// topic filter validator testbench
// streams zero-terminated topics and filters through the byte channel, runs a
// local model of the length and wildcard rules on every accepted byte and
// compares each status transfer with the oldest predicted status; the length
// limit is rewritten between phases while the unit is idle, both channels
// stall at random, and short filler topics probe the length limit boundary
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tfv_pkg::*;

  logic clk;
  logic rst_n;

  tfv_in_if  in_ch ();
  tfv_out_if out_ch ();
  tfv_cfg_if cfg_ch ();

  topic_filter_validator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // pending topic bytes and predicted statuses
  item_t   byte_q[$];
  status_t status_q[$];

  // local copy of the unit's topic state and limit
  logic [LIMIT_W-1:0] length_limit = LIMIT_RESET;
  logic [LEN_W-1:0]   topic_len    = '0;
  logic [LVL_W-1:0]   lvl_len      = '0;
  logic               lvl_plus     = 1'b0;
  logic               lvl_hash     = 1'b0;
  logic               wc_err       = 1'b0;
  logic               mode_q       = 1'b0;

  int  errors         = 0;
  int  queued_bytes   = 0;
  int  bytes_seen     = 0;
  int  limits_written = 0;
  int  status_seen[5] = '{default: 0};
  int  in_gap         = 0;
  int  in_calm        = 0;
  int  out_stall      = 0;
  int  out_calm       = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic end_level(input bit last);
    if (lvl_plus && lvl_len != LVL_ONE) wc_err = 1'b1;
    if (lvl_hash && (lvl_len != LVL_ONE || !last)) wc_err = 1'b1;
    lvl_len  = '0;
    lvl_plus = 1'b0;
    lvl_hash = 1'b0;
  endtask

  task automatic scan_topic_byte(input logic [BYTE_W-1:0] b, input logic fm);
    status_t st;
    if (b != CH_NUL) begin
      if (topic_len == '0) mode_q = fm;
      if (topic_len != LEN_SAT) topic_len++;
      if (!mode_q) begin
        if (b == CH_PLUS || b == CH_HASH) wc_err = 1'b1;
      end else if (b == CH_SLASH) begin
        end_level(1'b0);
      end else begin
        if (b == CH_PLUS) lvl_plus = 1'b1;
        if (b == CH_HASH) lvl_hash = 1'b1;
        if (lvl_len != LVL_SAT) lvl_len++;
      end
    end else begin
      if (topic_len == '0) begin
        st = ST_EMPTY;
      end else if (topic_len > {1'b0, length_limit}) begin
        st = ST_TOO_LONG;
      end else begin
        if (mode_q) end_level(1'b1);
        if (wc_err) st = mode_q ? ST_BAD_PLACEMENT : ST_PUB_WILDCARD;
        else st = ST_OK;
      end
      status_q.push_back(st);
      topic_len = '0;
      lvl_len   = '0;
      lvl_plus  = 1'b0;
      lvl_hash  = 1'b0;
      wc_err    = 1'b0;
      mode_q    = 1'b0;
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    item_t cur;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        cur = byte_q.pop_front();
        in_ch.topic_byte  <= cur.topic_byte;
        in_ch.filter_mode <= cur.filter_mode;
        in_ch.valid       <= 1'b1;
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(30, 120);
          in_gap = gap_len();
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // status back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (out_calm > 0) begin
      out_calm--;
      out_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(30, 120);
      out_stall = gap_len();
      out_ch.ready <= (out_stall == 0);
      if (out_stall > 0) out_stall--;
    end
  end

  // monitor: predict on byte transfers, check on status transfers
  always @(posedge clk) begin
    status_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) length_limit = cfg_ch.max_topic_length;
      if (in_ch.valid && in_ch.ready) begin
        bytes_seen++;
        scan_topic_byte(in_ch.topic_byte, in_ch.filter_mode);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: status %0d with none expected", $time, out_ch.status);
        end else begin
          want = status_q.pop_front();
          status_seen[int'(want)]++;
          if (out_ch.status !== want) begin
            errors++;
            $display("%0t: status mismatch, expected %0d (%s) got %0d",
                     $time, want, want.name(), out_ch.status);
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fm);
    item_t it;
    it.topic_byte  = b;
    it.filter_mode = fm;
    byte_q.push_back(it);
    queued_bytes++;
  endtask

  // first byte carries fm, the rest and the terminator carry fm_rest
  task automatic push_topic(input string s, input logic fm, input logic fm_rest);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], (i == 0) ? fm : fm_rest);
    push_byte(CH_NUL, fm_rest);
  endtask

  task automatic push_filler(input int n, input logic fm);
    for (int i = 0; i < n; i++) push_byte(8'h61 + 8'(i % 26), fm);
    push_byte(CH_NUL, fm);
  endtask

  task automatic push_random_topic();
    logic [BYTE_W-1:0] chars[$];
    logic              fm;
    int                levels;
    int                kind;
    int                n;
    int                r;
    fm     = 1'($urandom_range(0, 1));
    levels = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
    for (int l = 0; l < levels; l++) begin
      kind = $urandom_range(0, 9);
      if (!fm && kind < 5 && $urandom_range(0, 3) != 0) kind = 9;
      if (l == levels - 1 && kind == 2 && $urandom_range(0, 1) == 0) kind = 5;
      if (l != 0) chars.push_back(CH_SLASH);
      case (kind)
        0, 1: chars.push_back(CH_PLUS);
        2: chars.push_back(CH_HASH);
        3: ;
        4: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 3);
            case (r)
              0: chars.push_back(CH_PLUS);
              1: chars.push_back(CH_HASH);
              2: chars.push_back(CH_SLASH);
              default: chars.push_back(8'($urandom_range(1, 255)));
            endcase
          end
        end
        default: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
          for (int i = 0; i < n; i++)
            chars.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(8'h61, 8'h7a)));
        end
      endcase
    end
    // mode bits after the first byte are mostly consistent, sometimes flipped
    foreach (chars[i])
      push_byte(chars[i], (i == 0 || $urandom_range(0, 7) != 0) ? fm : ~fm);
    push_byte(CH_NUL, ($urandom_range(0, 7) == 0) ? ~fm : fm);
  endtask

  task automatic push_random_run(input int n);
    int target;
    target = queued_bytes + n;
    while (queued_bytes < target) push_random_topic();
  endtask

  task automatic drain();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_ch.valid || status_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.max_topic_length <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    limits_written++;
    @(negedge clk);
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.topic_byte        = '0;
    in_ch.filter_mode       = 1'b0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.max_topic_length = LIMIT_RESET;

    // wildcard rules under the reset limit
    push_topic("", 1'b0, 1'b0);
    push_topic("", 1'b1, 1'b1);
    push_topic("a/b", 1'b0, 1'b0);
    push_topic("s/+/x", 1'b0, 1'b0);
    push_topic("#", 1'b0, 1'b0);
    push_topic("+/a/#", 1'b1, 1'b1);
    push_topic("a+/b", 1'b1, 1'b1);
    push_topic("a/#/b", 1'b1, 1'b1);
    push_topic("a//b", 1'b1, 1'b1);
    push_topic("/", 1'b1, 1'b1);
    push_topic("##", 1'b1, 1'b1);
    push_topic("#/", 1'b1, 1'b1);
    push_topic("++", 1'b1, 1'b1);
    push_topic("+", 1'b1, 1'b1);
    push_topic("#", 1'b1, 1'b1);
    // mode is held from the first byte
    push_topic("a+/#", 1'b0, 1'b1);
    push_topic("+/#", 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(CH_NUL, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    write_length_limit('0);
    push_topic("", 1'b0, 1'b0);
    push_topic("a", 1'b0, 1'b0);
    push_topic("+", 1'b1, 1'b1);
    push_random_run(120);
    drain();

    write_length_limit(16'd1);
    push_topic("a", 1'b0, 1'b0);
    push_topic("ab", 1'b0, 1'b0);
    push_topic("#", 1'b0, 1'b0);
    push_topic("+", 1'b1, 1'b1);
    push_random_run(160);
    drain();

    // limit boundary
    write_length_limit(16'd3);
    push_filler(3, 1'b0);
    push_filler(4, 1'b1);
    push_random_run(170);
    drain();

    write_length_limit(16'($urandom_range(4, 24)));
    push_random_run(130);
    drain();

    write_length_limit(16'($urandom_range(1, 65535)));
    push_random_run(170);
    drain();

    write_length_limit(LIMIT_RESET);
    push_random_run(170);
    drain();
    repeat (6) @(posedge clk);

    $display("covered %0d topic bytes and %0d statuses over %0d limit writes",
             bytes_seen, status_seen.sum(), limits_written);
    $display("statuses: ok %0d, empty %0d, too long %0d, publish wildcard %0d, placement %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
